[rtl/core/murs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package murs_pkg;
   localparam int MaxJobs = 1024;
   localparam int SizeBits = 30;
   localparam int BudgetBits = 40;
   localparam int AddrBits = $clog2(MaxJobs);
   localparam int CountBits = AddrBits + 1;
   localparam int QDepth = 2;

   typedef struct packed {
      logic [CountBits-1:0] count;
      logic [SizeBits-1:0]  largest;
   } set_desc_type;
endpackage
`default_nettype wire

[rtl/core/murs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module murs_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

[rtl/core/murs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module murs_front import murs_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [SizeBits-1:0] req_job_size,
   input  wire logic                req_is_last,
   input  wire logic                back_busy,
   output logic                     wr_en,
   output logic [AddrBits-1:0]      wr_addr,
   output logic [SizeBits-1:0]      wr_data,
   output logic                     set_valid,
   output set_desc_type             set_desc
);
   logic [CountBits-1:0] count_ff, count_in;
   logic [SizeBits-1:0]  largest_ff, largest_in;
   logic                 accept, room;

   // The store is shared with the back part, so loading waits while it searches.
   assign req_ready = !back_busy;
   assign accept = req_valid && req_ready;
   assign room = count_ff < CountBits'(MaxJobs);
   assign wr_en = accept && room;
   assign wr_addr = count_ff[AddrBits-1:0];
   assign wr_data = req_job_size;

   always_comb begin
      count_in = count_ff;
      largest_in = largest_ff;
      if (wr_en) begin
         count_in = count_ff + 1'b1;
         if (req_job_size > largest_ff) begin
            largest_in = req_job_size;
         end
      end
   end

   assign set_valid = accept && req_is_last;
   assign set_desc.count = count_in;
   assign set_desc.largest = largest_in;

   always_ff @(posedge clock) begin
      if (reset || set_valid) begin
         count_ff <= '0;
         largest_ff <= '0;
      end else begin
         count_ff <= count_in;
         largest_ff <= largest_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CountBits'(MaxJobs))
      else $error("job count overflow");
   assert property (@(posedge clock) disable iff (reset) set_valid |=> count_ff == '0)
      else $error("set not cleared");
   assert property (@(posedge clock) disable iff (reset) back_busy |-> !wr_en)
      else $error("store written during search");
endmodule
`default_nettype wire

[rtl/core/murs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module murs_back import murs_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [BudgetBits-1:0] budget,
   input  wire logic                  set_valid,
   input  wire set_desc_type          set_desc,
   output logic                       busy,
   output logic [AddrBits-1:0]        rd_addr,
   input  wire logic [SizeBits-1:0]   rd_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [SizeBits-1:0]        rsp_min_rate,
   output logic                       rsp_feasible
);
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StProbe = 3'd1;
   localparam logic [2:0] StDiv = 3'd2;
   localparam logic [2:0] StJudge = 3'd3;
   localparam logic [2:0] StOut = 3'd4;
   localparam int DivCntBits = $clog2(SizeBits + 1);

   // Two-entry queue of closed sets between loading and searching.
   set_desc_type         q_ff [QDepth];
   logic [1:0]           q_cnt_ff;
   logic                 q_rd_ff, q_wr_ff;
   logic [2:0]           st_ff;
   set_desc_type         cur_ff;
   logic [SizeBits-1:0]  lo_ff, hi_ff, mid_ff;
   logic [CountBits-1:0] idx_ff;
   logic                 wait_ff;
   logic [BudgetBits:0]  total_ff;
   logic [SizeBits-1:0]  quot_ff, rem_ff;
   logic [DivCntBits-1:0] dcnt_ff;
   logic                 nz_ff;
   logic                 pop;
   logic [SizeBits:0]    trial;
   logic [SizeBits-1:0]  rem_next;
   logic [SizeBits-1:0]  hi_init;
   logic [BudgetBits:0]  sum_next;

   assign pop = (st_ff == StIdle) && (q_cnt_ff != 2'd0);
   assign busy = (st_ff != StIdle) || (q_cnt_ff != 2'd0);
   assign rd_addr = idx_ff[AddrBits-1:0];
   assign trial = {rem_ff, quot_ff[SizeBits-1]};
   assign rem_next = (trial >= {1'b0, mid_ff}) ? SizeBits'(trial - {1'b0, mid_ff})
                                               : trial[SizeBits-1:0];
   assign hi_init = (q_ff[q_rd_ff].largest != '0) ? q_ff[q_rd_ff].largest : SizeBits'(1);
   assign sum_next = total_ff + (BudgetBits+1)'(quot_ff) + (BudgetBits+1)'(nz_ff);

   always_ff @(posedge clock) begin
      if (set_valid) begin
         q_ff[q_wr_ff] <= set_desc;
      end
      if (reset) begin
         q_cnt_ff <= '0;
         q_rd_ff <= 1'b0;
         q_wr_ff <= 1'b0;
         st_ff <= StIdle;
         rsp_valid <= 1'b0;
      end else begin
         q_cnt_ff <= q_cnt_ff + {1'b0, set_valid} - {1'b0, pop};
         if (set_valid) q_wr_ff <= !q_wr_ff;
         if (pop) q_rd_ff <= !q_rd_ff;
         unique case (st_ff)
            StIdle: begin
               if (pop) begin
                  cur_ff <= q_ff[q_rd_ff];
                  lo_ff <= SizeBits'(1);
                  hi_ff <= hi_init;
                  if ({{(BudgetBits-CountBits){1'b0}}, q_ff[q_rd_ff].count} > budget) begin
                     rsp_min_rate <= '0;
                     rsp_feasible <= 1'b0;
                     rsp_valid <= 1'b1;
                     st_ff <= StOut;
                  end else if (hi_init == SizeBits'(1)) begin
                     rsp_min_rate <= SizeBits'(1);
                     rsp_feasible <= 1'b1;
                     rsp_valid <= 1'b1;
                     st_ff <= StOut;
                  end else begin
                     mid_ff <= SizeBits'(1) + ((hi_init - SizeBits'(1)) >> 1);
                     idx_ff <= '0;
                     total_ff <= '0;
                     wait_ff <= 1'b1;
                     st_ff <= StProbe;
                  end
               end
            end
            StProbe: begin
               if (idx_ff == cur_ff.count) begin
                  st_ff <= StJudge;
               end else if (wait_ff) begin
                  wait_ff <= 1'b0;
               end else begin
                  // Restoring division of size by the trial rate, one bit a cycle.
                  quot_ff <= rd_data;
                  rem_ff <= '0;
                  dcnt_ff <= DivCntBits'(SizeBits);
                  st_ff <= StDiv;
               end
            end
            StDiv: begin
               if (dcnt_ff == '0) begin
                  total_ff <= (sum_next > (BudgetBits+1)'(budget)) ?
                              (BudgetBits+1)'(budget) + 1'b1 : sum_next;
                  idx_ff <= idx_ff + 1'b1;
                  wait_ff <= 1'b1;
                  st_ff <= StProbe;
               end else begin
                  rem_ff <= rem_next;
                  quot_ff <= {quot_ff[SizeBits-2:0], trial >= {1'b0, mid_ff}};
                  nz_ff <= (dcnt_ff == DivCntBits'(1)) && (rem_next != '0);
                  dcnt_ff <= dcnt_ff - 1'b1;
               end
            end
            StJudge: begin
               if (total_ff <= (BudgetBits+1)'(budget)) begin
                  if (lo_ff == mid_ff) begin
                     rsp_min_rate <= mid_ff;
                     rsp_feasible <= 1'b1;
                     rsp_valid <= 1'b1;
                     st_ff <= StOut;
                  end else begin
                     hi_ff <= mid_ff;
                     mid_ff <= lo_ff + ((mid_ff - lo_ff) >> 1);
                     idx_ff <= '0;
                     total_ff <= '0;
                     wait_ff <= 1'b1;
                     st_ff <= StProbe;
                  end
               end else if (mid_ff + 1'b1 == hi_ff) begin
                  rsp_min_rate <= hi_ff;
                  rsp_feasible <= 1'b1;
                  rsp_valid <= 1'b1;
                  st_ff <= StOut;
               end else begin
                  lo_ff <= mid_ff + 1'b1;
                  mid_ff <= mid_ff + 1'b1 + ((hi_ff - mid_ff - 1'b1) >> 1);
                  idx_ff <= '0;
                  total_ff <= '0;
                  wait_ff <= 1'b1;
                  st_ff <= StProbe;
               end
            end
            StOut: begin
               if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  st_ff <= StIdle;
               end
            end
            default: st_ff <= StIdle;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) q_cnt_ff <= 2'(QDepth))
      else $error("set queue overflow");
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> st_ff == StOut)
      else $error("result outside output state");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == StJudge) |-> (lo_ff <= mid_ff && mid_ff < hi_ff))
      else $error("search interval broken");
endmodule
`default_nettype wire

[rtl/core/min_uniform_rate_search.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Signals
// req       in         req_valid, req_ready, req_job_size, req_is_last
// rsp       out        rsp_valid, rsp_ready, rsp_min_rate, rsp_feasible
// csr       in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
// Sizes load at one item a cycle into a 1024-entry store.
// The search takes about log2(largest size) probes, each of which walks the store
// through the single bit-serial divider, one job at a time.
// Loading stalls while a search runs, since both use the store.
// Synchronous reset clears counts, the queue and the budget (to 1).
module min_uniform_rate_search import murs_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [SizeBits-1:0] req_job_size,
   input  wire logic                req_is_last,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [SizeBits-1:0]      rsp_min_rate,
   output logic                     rsp_feasible,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [3:0]          paddr,
   input  wire logic [63:0]         pwdata,
   output logic [63:0]              prdata,
   output logic                     pready
);
   logic [BudgetBits-1:0] budget_ff;
   logic                  wr_en, set_valid, busy;
   logic [AddrBits-1:0]   wr_addr, rd_addr;
   logic [SizeBits-1:0]   wr_data, rd_data;
   set_desc_type          set_desc;

   assign pready = 1'b1;
   assign prdata = (paddr == 4'd0) ? {{(64-BudgetBits){1'b0}}, budget_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BudgetBits'(1);
      end else if (psel && penable && pwrite && paddr == 4'd0) begin
         budget_ff <= pwdata[BudgetBits-1:0];
      end
   end

   murs_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_job_size, .req_is_last,
      .back_busy(busy), .wr_en, .wr_addr, .wr_data, .set_valid, .set_desc
   );

   murs_ram #(.Width(SizeBits), .Depth(MaxJobs)) u_store (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   murs_back u_back (
      .clock, .reset, .budget(budget_ff), .set_valid, .set_desc, .busy, .rd_addr,
      .rd_data, .rsp_valid, .rsp_ready, .rsp_min_rate, .rsp_feasible
   );
endmodule
`default_nettype wire
